[hw/rtl/gqg_pkg.sv]
// ----------------------------------------------------------------------------
// gqg_pkg: shared types and constants of the glyph quad generator
// Table geometry, opcodes, register indexes, divider sizes and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package gqg_pkg;

	// glyph table geometry
	localparam int MAX_GLYPHS = 256;
	localparam int IDX_W      = $clog2(MAX_GLYPHS);
	localparam int CNT_W      = $clog2(MAX_GLYPHS + 1);

	// divider: 36 bit signed numerator, 35 bit magnitude, 14 bit divisor
	localparam int NUM_W  = 36;
	localparam int MAG_W  = 35;
	localparam int DEN_W  = 14;
	localparam int QS_W   = 37;
	localparam int STEP_W = 6;
	localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(MAG_W);

	// opcodes
	localparam logic [2:0] OP_CLEAR    = 3'd0;
	localparam logic [2:0] OP_APPEND   = 3'd1;
	localparam logic [2:0] OP_PEN      = 3'd2;
	localparam logic [2:0] OP_DRAW     = 3'd3;
	localparam logic [2:0] OP_VRESTART = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_TEX_W   = 2'd0;
	localparam logic [1:0] REG_TEX_H   = 2'd1;
	localparam logic [1:0] REG_GLYPH_H = 2'd2;

	// per-glyph division jobs, in issue order
	localparam logic [3:0] JOB_X0  = 4'd0;
	localparam logic [3:0] JOB_X1  = 4'd1;
	localparam logic [3:0] JOB_Y0  = 4'd2;
	localparam logic [3:0] JOB_Y1  = 4'd3;
	localparam logic [3:0] JOB_ADV = 4'd4;
	localparam logic [3:0] JOB_U0  = 4'd5;
	localparam logic [3:0] JOB_U1  = 4'd6;
	localparam logic [3:0] JOB_V0  = 4'd7;
	localparam logic [3:0] JOB_V1  = 4'd8;

	// output beats: four vertices then six indices
	localparam logic [3:0] BEAT_FIRST_IDX = 4'd4;
	localparam logic [3:0] BEAT_LAST      = 4'd9;

	localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] POS_MIN = -24'sh800000;
	localparam logic [16:0]        TEX_ONE = 17'h10000;

	// one stored glyph entry; ty and oy are kept already flipped
	typedef struct packed {
		logic [15:0]        code;
		logic [11:0]        tx;
		logic signed [13:0] ty;
		logic [11:0]        w;
		logic [11:0]        h;
		logic signed [11:0] ox;
		logic signed [13:0] oy;
		logic [11:0]        adv;
		logic [11:0]        lh;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic       op_exec;
		logic       srch_init;
		logic       srch_rd;
		logic       srch_next;
		logic       mul_go;
		logic       div_load;
		logic       div_step;
		logic       store;
		logic       beat_next;
		logic       draw_finish;
		logic [3:0] job;
	} ctrl_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic srch_hit;
		logic srch_end;
		logic lh_zero;
		logic div_done;
		logic beat_last;
	} dp_stat_t;

	// vertex offset of each index beat: 0 1 2 1 2 3
	function automatic logic [1:0] idx_offset(input logic [3:0] beat);
		logic [1:0] r;
		case (beat)
			4'd4:    r = 2'd0;
			4'd5:    r = 2'd1;
			4'd6:    r = 2'd2;
			4'd7:    r = 2'd1;
			4'd8:    r = 2'd2;
			4'd9:    r = 2'd3;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/gqg_ram.sv]
// ----------------------------------------------------------------------------
// gqg_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gqg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/gqg_ctrl.sv]
// ----------------------------------------------------------------------------
// gqg_ctrl: sequencer of the glyph quad generator
// Takes input beats, walks the table search, runs the nine division jobs
// of a glyph and hands out the ten output beats.
// ----------------------------------------------------------------------------
module gqg_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         op,
	output logic               out_valid,
	input  logic               out_ready,
	input  gqg_pkg::dp_stat_t  stat,
	output gqg_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_SRCH_RD = 8'b0000_0010,
		ST_SRCH_CM = 8'b0000_0100,
		ST_MUL     = 8'b0000_1000,
		ST_DIVLD   = 8'b0001_0000,
		ST_DIV     = 8'b0010_0000,
		ST_STORE   = 8'b0100_0000,
		ST_EMIT    = 8'b1000_0000
	} state_t;

	state_t     state_q, state_d;
	logic [3:0] job_q, job_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);

	// next state and commands
	always_comb begin
		state_d = state_q;
		job_d   = job_q;
		cmd     = '0;
		cmd.job = job_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op_exec = 1'b1;
					if (op == gqg_pkg::OP_DRAW && !stat.count_zero) begin
						cmd.srch_init = 1'b1;
						state_d       = ST_SRCH_RD;
					end
				end
			end
			ST_SRCH_RD: begin
				cmd.srch_rd = 1'b1;
				state_d     = ST_SRCH_CM;
			end
			ST_SRCH_CM: begin
				if (stat.srch_hit) begin
					// zero line height draws nothing
					if (stat.lh_zero) begin
						state_d = ST_IDLE;
					end else begin
						job_d   = gqg_pkg::JOB_X0;
						state_d = ST_MUL;
					end
				end else if (stat.srch_end) begin
					state_d = ST_IDLE;
				end else begin
					cmd.srch_next = 1'b1;
					state_d       = ST_SRCH_RD;
				end
			end
			ST_MUL: begin
				cmd.mul_go = 1'b1;
				state_d    = ST_DIVLD;
			end
			ST_DIVLD: begin
				cmd.div_load = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_done) begin
					state_d = ST_STORE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				if (job_q == gqg_pkg::JOB_V1) begin
					state_d = ST_EMIT;
				end else begin
					job_d   = job_q + 4'd1;
					state_d = ST_MUL;
				end
			end
			ST_EMIT: begin
				if (out_ready) begin
					if (stat.beat_last) begin
						cmd.draw_finish = 1'b1;
						state_d         = ST_IDLE;
					end else begin
						cmd.beat_next = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			job_q   <= gqg_pkg::JOB_X0;
		end else begin
			state_q <= state_d;
			job_q   <= job_d;
		end
	end

endmodule

[hw/rtl/gqg_dp.sv]
// ----------------------------------------------------------------------------
// gqg_dp: datapath of the glyph quad generator
// Config registers, glyph table, pen and vertex counters, one scaling
// multiplier, one radix-2 divider and the output beat mux.
// ----------------------------------------------------------------------------
module gqg_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_addr,
	input  logic [15:0]               cfg_wdata,
	input  logic [2:0]                op,
	input  logic [15:0]               code,
	input  logic [11:0]               tex_x,
	input  logic [11:0]               tex_y,
	input  logic [11:0]               glyph_w,
	input  logic [11:0]               glyph_h,
	input  logic signed [11:0]        off_x,
	input  logic signed [11:0]        off_y,
	input  logic [11:0]               adv_w,
	input  logic [11:0]               line_h,
	input  logic signed [23:0]        pen_x,
	input  logic signed [23:0]        pen_y,
	input  gqg_pkg::ctrl_cmd_t        cmd,
	output gqg_pkg::dp_stat_t         stat,
	output logic                      kind,
	output logic signed [23:0]        pos_x,
	output logic signed [23:0]        pos_y,
	output logic [16:0]               tex_u,
	output logic [16:0]               tex_v,
	output logic [15:0]               index_value,
	output logic                      last
);

	// config registers
	logic [12:0] tex_w_q, tex_h_q;
	logic [15:0] glyph_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_w_q   <= 13'd256;
			tex_h_q   <= 13'd256;
			glyph_h_q <= 16'd256;
		end else if (cfg_we) begin
			case (cfg_addr)
				gqg_pkg::REG_TEX_W:   tex_w_q   <= cfg_wdata[12:0];
				gqg_pkg::REG_TEX_H:   tex_h_q   <= cfg_wdata[12:0];
				gqg_pkg::REG_GLYPH_H: glyph_h_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// op decode on an accepted input beat
	logic op_append, op_clear, op_pen, op_vrst;
	assign op_clear  = cmd.op_exec && (op == gqg_pkg::OP_CLEAR);
	assign op_append = cmd.op_exec && (op == gqg_pkg::OP_APPEND);
	assign op_pen    = cmd.op_exec && (op == gqg_pkg::OP_PEN);
	assign op_vrst   = cmd.op_exec && (op == gqg_pkg::OP_VRESTART);

	// glyph table
	logic [gqg_pkg::CNT_W-1:0] count_q;
	logic [gqg_pkg::IDX_W-1:0] srch_idx_q;
	logic                      tbl_full, tbl_we;
	gqg_pkg::entry_t           wr_entry, e;
	logic [gqg_pkg::ENTRY_W-1:0] rd_data;

	assign tbl_full = (count_q == gqg_pkg::CNT_W'(gqg_pkg::MAX_GLYPHS));
	assign tbl_we   = op_append && !tbl_full;

	// flip texture y and offset y on the way in
	always_comb begin
		wr_entry.code = code;
		wr_entry.tx   = tex_x;
		wr_entry.ty   = $signed({1'b0, tex_h_q}) - $signed({2'b00, tex_y})
		              - $signed({2'b00, glyph_h});
		wr_entry.w    = glyph_w;
		wr_entry.h    = glyph_h;
		wr_entry.ox   = off_x;
		wr_entry.oy   = $signed({2'b00, line_h}) - $signed({2'b00, glyph_h})
		              - $signed({{2{off_y[11]}}, off_y});
		wr_entry.adv  = adv_w;
		wr_entry.lh   = line_h;
	end

	gqg_ram #(
		.WIDTH (gqg_pkg::ENTRY_W),
		.DEPTH (gqg_pkg::MAX_GLYPHS)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (count_q[gqg_pkg::IDX_W-1:0]),
		.wdata (wr_entry),
		.re    (cmd.srch_rd),
		.raddr (srch_idx_q),
		.rdata (rd_data)
	);

	assign e = gqg_pkg::entry_t'(rd_data);

	// counters, pen and draw code
	logic signed [23:0] pen_x_q, pen_y_q;
	logic [15:0]        vcount_q, code_q;
	logic [3:0]         beat_q;
	logic signed [23:0] sat_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			srch_idx_q <= '0;
			pen_x_q    <= '0;
			pen_y_q    <= '0;
			vcount_q   <= '0;
			beat_q     <= '0;
		end else begin
			if (op_clear) begin
				count_q <= '0;
			end else if (tbl_we) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.srch_init) begin
				srch_idx_q <= '0;
				beat_q     <= '0;
			end else if (cmd.srch_next) begin
				srch_idx_q <= srch_idx_q + 1'b1;
			end else if (cmd.beat_next) begin
				beat_q <= beat_q + 4'd1;
			end
			if (op_pen) begin
				pen_x_q <= pen_x;
				pen_y_q <= pen_y;
			end else if (cmd.store && cmd.job == gqg_pkg::JOB_ADV) begin
				pen_x_q <= sat_res;
			end
			if (op_vrst) begin
				vcount_q <= '0;
			end else if (cmd.draw_finish) begin
				vcount_q <= vcount_q + 16'd4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op_exec) begin
			code_q <= code;
		end
	end

	// operand of the current job
	logic signed [13:0] n_sel, ox14, oy14, ty14, w14, h14, tx14;
	logic               is_scl;
	logic [12:0]        tdiv;

	assign ox14   = {{2{e.ox[11]}}, e.ox};
	assign oy14   = e.oy;
	assign ty14   = e.ty;
	assign w14    = $signed({2'b00, e.w});
	assign h14    = $signed({2'b00, e.h});
	assign tx14   = $signed({2'b00, e.tx});
	assign is_scl = (cmd.job <= gqg_pkg::JOB_ADV);

	always_comb begin
		case (cmd.job)
			gqg_pkg::JOB_X0:  n_sel = ox14;
			gqg_pkg::JOB_X1:  n_sel = ox14 + w14;
			gqg_pkg::JOB_Y0:  n_sel = oy14;
			gqg_pkg::JOB_Y1:  n_sel = oy14 + h14;
			gqg_pkg::JOB_ADV: n_sel = $signed({2'b00, e.adv});
			gqg_pkg::JOB_U0:  n_sel = tx14;
			gqg_pkg::JOB_U1:  n_sel = tx14 + w14;
			gqg_pkg::JOB_V0:  n_sel = ty14;
			gqg_pkg::JOB_V1:  n_sel = ty14 + h14;
			default:          n_sel = '0;
		endcase
	end

	// texture divisor, zero acts as one
	always_comb begin
		if (cmd.job <= gqg_pkg::JOB_U1) begin
			tdiv = (tex_w_q == 13'd0) ? 13'd1 : tex_w_q;
		end else begin
			tdiv = (tex_h_q == 13'd0) ? 13'd1 : tex_h_q;
		end
	end

	// scale multiplier, registered
	logic signed [30:0] prod_q;

	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			prod_q <= n_sel * $signed({1'b0, glyph_h_q});
		end
	end

	// rounded quotient floor((2n + d) / 2d) as numerator and divisor
	logic signed [gqg_pkg::NUM_W-1:0] num_w, num_abs;
	logic [gqg_pkg::DEN_W-1:0]        den_w;

	always_comb begin
		if (is_scl) begin
			num_w = $signed({prod_q, 5'b00000}) + $signed({24'd0, e.lh});
			den_w = {1'b0, e.lh, 1'b0};
		end else begin
			num_w = $signed({{5{n_sel[13]}}, n_sel, 17'd0})
			      + $signed({23'd0, tdiv});
			den_w = {tdiv, 1'b0};
		end
		num_abs = num_w[gqg_pkg::NUM_W-1] ? -num_w : num_w;
	end

	// radix-2 restoring divider on the magnitude
	logic [gqg_pkg::MAG_W-1:0]  mag_q;
	logic [gqg_pkg::DEN_W-1:0]  rem_q, den_q;
	logic                       neg_q;
	logic [gqg_pkg::STEP_W-1:0] cnt_q;
	logic [gqg_pkg::DEN_W:0]    r2, diff;
	logic                       ge;

	assign r2   = {rem_q, mag_q[gqg_pkg::MAG_W-1]};
	assign diff = r2 - {1'b0, den_q};
	assign ge   = (r2 >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_load) begin
			cnt_q <= gqg_pkg::DIV_STEPS;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			mag_q <= num_abs[gqg_pkg::MAG_W-1:0];
			rem_q <= '0;
			den_q <= den_w;
			neg_q <= num_w[gqg_pkg::NUM_W-1];
		end else if (cmd.div_step) begin
			mag_q <= {mag_q[gqg_pkg::MAG_W-2:0], ge};
			rem_q <= ge ? diff[gqg_pkg::DEN_W-1:0] : r2[gqg_pkg::DEN_W-1:0];
		end
	end

	// floor of a negative quotient steps down when the remainder is nonzero
	logic signed [gqg_pkg::QS_W-1:0] qmag, qs;
	logic signed [37:0]              pen_sel, sum38;
	logic [16:0]                     tex_res;

	assign qmag = $signed({2'b00, mag_q});
	assign qs   = neg_q ? -(qmag + $signed({36'd0, (rem_q != '0)})) : qmag;

	always_comb begin
		pen_sel = (cmd.job == gqg_pkg::JOB_Y0 || cmd.job == gqg_pkg::JOB_Y1)
		        ? 38'(pen_y_q) : 38'(pen_x_q);
		sum38   = pen_sel + 38'(qs);
		if (sum38 > 38'(gqg_pkg::POS_MAX)) begin
			sat_res = gqg_pkg::POS_MAX;
		end else if (sum38 < 38'(gqg_pkg::POS_MIN)) begin
			sat_res = gqg_pkg::POS_MIN;
		end else begin
			sat_res = sum38[23:0];
		end
		if (qs[gqg_pkg::QS_W-1]) begin
			tex_res = '0;
		end else if (qs > $signed({20'd0, gqg_pkg::TEX_ONE})) begin
			tex_res = gqg_pkg::TEX_ONE;
		end else begin
			tex_res = qs[16:0];
		end
	end

	// job results: x0 x1 y0 y1 and u0 u1 v0 v1
	logic signed [23:0] pos_q [4];
	logic [16:0]        tex_q [4];

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			case (cmd.job)
				gqg_pkg::JOB_X0: pos_q[0] <= sat_res;
				gqg_pkg::JOB_X1: pos_q[1] <= sat_res;
				gqg_pkg::JOB_Y0: pos_q[2] <= sat_res;
				gqg_pkg::JOB_Y1: pos_q[3] <= sat_res;
				gqg_pkg::JOB_U0: tex_q[0] <= tex_res;
				gqg_pkg::JOB_U1: tex_q[1] <= tex_res;
				gqg_pkg::JOB_V0: tex_q[2] <= tex_res;
				gqg_pkg::JOB_V1: tex_q[3] <= tex_res;
				default: ;
			endcase
		end
	end

	// status
	assign stat.count_zero = (count_q == '0);
	assign stat.srch_hit   = (e.code == code_q);
	assign stat.srch_end   = ((gqg_pkg::CNT_W'(srch_idx_q) + 1'b1) == count_q);
	assign stat.lh_zero    = (e.lh == 12'd0);
	assign stat.div_done   = (cnt_q == '0);
	assign stat.beat_last  = (beat_q == gqg_pkg::BEAT_LAST);

	// output beat mux
	logic [1:0] vsel;

	assign kind = (beat_q >= gqg_pkg::BEAT_FIRST_IDX);
	assign vsel = kind ? gqg_pkg::idx_offset(beat_q) : beat_q[1:0];
	assign last = (beat_q == gqg_pkg::BEAT_LAST);

	always_comb begin
		index_value = vcount_q + {14'd0, vsel};
		if (kind) begin
			pos_x = '0;
			pos_y = '0;
			tex_u = '0;
			tex_v = '0;
		end else begin
			pos_x = vsel[1] ? pos_q[1] : pos_q[0];
			pos_y = vsel[0] ? pos_q[2] : pos_q[3];
			tex_u = vsel[1] ? tex_q[1] : tex_q[0];
			tex_v = vsel[0] ? tex_q[2] : tex_q[3];
		end
	end

endmodule

[hw/rtl/glyph_quad_generator_top.sv]
// ----------------------------------------------------------------------------
// glyph_quad_generator_top: bitmap font text quad generator
// Glyph table, pen and vertex state; a draw beat turns into four vertex
// beats and six index beats.
//
//   channel | signals                          | beat
//   --------+----------------------------------+-------------------------
//   in      | in_valid, in_ready, op..pen_y    | one table/pen/draw op
//   out     | out_valid, out_ready, kind..last | one vertex or index item
//   cfg     | cfg_we, cfg_addr, cfg_wdata      | one register write
//
// Ops other than draw are done as accepted. A draw compares table entries
// up to the hit; a miss or zero line height ends it. A hit runs 9 divider
// jobs (35 steps each on one shared radix-2 unit), then 10 output beats.
// Reset clears the entry count, pen, vertex counter; config regs go to 256.
// A stall on out holds the current beat; no input is taken until the last
// index beat of a glyph leaves.
// ----------------------------------------------------------------------------
module glyph_quad_generator_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_addr,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         op,
	input  logic [15:0]        code,
	input  logic [11:0]        tex_x,
	input  logic [11:0]        tex_y,
	input  logic [11:0]        glyph_w,
	input  logic [11:0]        glyph_h,
	input  logic signed [11:0] off_x,
	input  logic signed [11:0] off_y,
	input  logic [11:0]        adv_w,
	input  logic [11:0]        line_h,
	input  logic signed [23:0] pen_x,
	input  logic signed [23:0] pen_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               kind,
	output logic signed [23:0] pos_x,
	output logic signed [23:0] pos_y,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic [15:0]        index_value,
	output logic               last
);

	gqg_pkg::ctrl_cmd_t cmd;
	gqg_pkg::dp_stat_t  stat;

	// sequencer
	gqg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath
	gqg_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.op          (op),
		.code        (code),
		.tex_x       (tex_x),
		.tex_y       (tex_y),
		.glyph_w     (glyph_w),
		.glyph_h     (glyph_h),
		.off_x       (off_x),
		.off_y       (off_y),
		.adv_w       (adv_w),
		.line_h      (line_h),
		.pen_x       (pen_x),
		.pen_y       (pen_y),
		.cmd         (cmd),
		.stat        (stat),
		.kind        (kind),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.tex_u       (tex_u),
		.tex_v       (tex_v),
		.index_value (index_value),
		.last        (last)
	);

endmodule

[hw/rtl/gqg_checker.sv]
// ----------------------------------------------------------------------------
// gqg_checker: port-level checks of the glyph quad generator
// Watches the handshakes and the beat framing seen at the top level.
// ----------------------------------------------------------------------------
module gqg_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic kind,
	input logic last
);

	// a stalled output beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped while stalled");

	// no input is taken while a glyph is still being emitted
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready during output");

	// last only marks an index beat
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> kind)
		else $error("last on a vertex beat");

	// after the last index beat the glyph is done
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> !out_valid && in_ready)
		else $error("output continues after last beat");

endmodule

bind glyph_quad_generator_top gqg_checker u_gqg_checker (.*);
